// ===== src/sensor_average_validate_convert_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sensor average/validate/convert - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SENSOR_AVERAGE_VALIDATE_CONVERT_TOP_DEFINES_SVH
`define SENSOR_AVERAGE_VALIDATE_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication
`define SAVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SAVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/savc_pkg.sv =====
// ----------------------------------------------------------------------------
// savc_pkg
// Types, widths and constants of the sensor average/validate/convert block.
// ----------------------------------------------------------------------------
package savc_pkg;

    localparam int CHAN_W    = 2;
    localparam int RAW_W     = 10;
    localparam int VALUE_W   = 19;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_MAX   = 1023;

    typedef enum logic [CHAN_W-1:0] {
        CH_GAS  = 2'd0,
        CH_TEMP = 2'd1,
        CH_SOIL = 2'd2,
        CH_NONE = 2'd3
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAS_MIN  = 3'd0,
        REG_GAS_MAX  = 3'd1,
        REG_TEMP_MIN = 3'd2,
        REG_TEMP_MAX = 3'd3,
        REG_SOIL_MIN = 3'd4,
        REG_SOIL_MAX = 3'd5,
        REG_SOIL_DRY = 3'd6,
        REG_SOIL_WET = 3'd7
    } cfg_idx_t;

    localparam logic [RAW_W-1:0] GAS_MIN_RST  = 10'd50;
    localparam logic [RAW_W-1:0] GAS_MAX_RST  = 10'd950;
    localparam logic [RAW_W-1:0] TEMP_MIN_RST = 10'd100;
    localparam logic [RAW_W-1:0] TEMP_MAX_RST = 10'd600;
    localparam logic [RAW_W-1:0] SOIL_MIN_RST = 10'd10;
    localparam logic [RAW_W-1:0] SOIL_MAX_RST = 10'd990;
    localparam logic [RAW_W-1:0] SOIL_DRY_RST = 10'd800;
    localparam logic [RAW_W-1:0] SOIL_WET_RST = 10'd300;
    localparam logic [RAW_W-1:0] RAW_FULL     = 10'd1023;

    // Serial restoring divider
    localparam int DIV_W  = 17;
    localparam int DEN_W  = 10;
    localparam int DIVC_W = $clog2(DIV_W);
    localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(DIV_W - 1);

    // Soil percentage
    localparam int PCT_W    = 7;
    localparam int PCT_FULL = 100;

    // Temperature: a * 500 / 1024, rounded half up
    localparam int TEMP_W     = 40;
    localparam int TEMP_SCALE = 500;
    localparam int TEMP_HALF  = 512;
    localparam int TEMP_SHIFT = 10;
    localparam int TEMP_FAIL  = 1000;

    // Gas: exact power compare, 8-bit digit-serial big multiplier
    localparam int GAS_K2     = 40;
    localparam int GAS_ZERO_A = 1000000;
    localparam int DIG_W      = 8;
    localparam int BIG_W      = 320;
    localparam int NDIG       = BIG_W / DIG_W;
    localparam int DIGC_W     = $clog2(NDIG);
    localparam int SEARCH_W   = 25;
    localparam int BIT_W      = $clog2(SEARCH_W);
    localparam int MUL_W      = SEARCH_W + 1;
    localparam int PROD_W     = DIG_W + MUL_W;
    localparam int POW_N      = 10;
    localparam int NPASS      = POW_N + 3;
    localparam int PASS_W     = $clog2(NPASS);

    localparam logic [DIGC_W-1:0] DIG_LAST  = DIGC_W'(NDIG - 1);
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(NPASS - 1);
    localparam logic [PASS_W-1:0] PASS_POW  = PASS_W'(POW_N);
    localparam logic [BIT_W-1:0]  BIT_TOP   = BIT_W'(SEARCH_W - 1);

endpackage

// ===== src/sensor_average_validate_convert_top.sv =====
// ----------------------------------------------------------------------------
// sensor_average_validate_convert_top
// Per-channel ADC averaging, window check and fixed-point conversion.
// ----------------------------------------------------------------------------
// A sample that does not complete its channel's average is only accumulated.
// The sample that completes it starts a result: serial division for the
// mean, the window check, and the hand-over of the result to the output
// register. Temperature readings and failed checks take only these steps;
// soil adds a second serial division for the moisture map. Gas readings
// run an exact rounding search of 25 trials on an 8-bit digit-serial
// multiplier over a 320-bit operand: 26 sequences of 13 passes of 40 digits.
// Samples wait while a result is being formed; they are taken while a
// finished result still sits in the output register. Channel code 3 is
// accepted and dropped.
// ----------------------------------------------------------------------------
`include "sensor_average_validate_convert_top_defines.svh"

module sensor_average_validate_convert_top #(
    parameter int SAMPLES_PER_AVERAGE = 20,
    parameter int FRACTION_BITS       = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [savc_pkg::CHAN_W-1:0]          s_channel,
    input  logic [savc_pkg::RAW_W-1:0]           s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [savc_pkg::CHAN_W-1:0]          m_out_channel,
    output logic                                 m_connected,
    output logic [savc_pkg::RAW_W-1:0]           m_average_raw,
    output logic signed [savc_pkg::VALUE_W-1:0]  m_value_q8,
    input  logic                                 cfg_wr_en,
    input  logic [savc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [savc_pkg::RAW_W-1:0]           cfg_wdata
);

    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * savc_pkg::RAW_MAX + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int VW    = savc_pkg::VALUE_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES_PER_AVERAGE);
    localparam logic [savc_pkg::DEN_W-1:0] AVG_DEN =
        savc_pkg::DEN_W'(SAMPLES_PER_AVERAGE);

    localparam logic signed [31:0] GAS_SENT_I  = -(32'sd1 <<< FRACTION_BITS);
    localparam logic signed [31:0] TEMP_SENT_I =
        -(32'(savc_pkg::TEMP_FAIL) <<< FRACTION_BITS);
    localparam logic [VW-1:0] GAS_SENT  = GAS_SENT_I[VW-1:0];
    localparam logic [VW-1:0] TEMP_SENT = TEMP_SENT_I[VW-1:0];

    localparam logic [31:0] K2_I = 32'(savc_pkg::GAS_K2) << FRACTION_BITS;
    localparam logic [savc_pkg::MUL_W-1:0] GAS_K2Q = K2_I[savc_pkg::MUL_W-1:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_CHECK,
        ST_DIV_SOIL,
        ST_GAS_RHS,
        ST_GAS_TRY,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [savc_pkg::RAW_W-1:0] gas_min_reg, gas_min_next;
    logic [savc_pkg::RAW_W-1:0] gas_max_reg, gas_max_next;
    logic [savc_pkg::RAW_W-1:0] temp_min_reg, temp_min_next;
    logic [savc_pkg::RAW_W-1:0] temp_max_reg, temp_max_next;
    logic [savc_pkg::RAW_W-1:0] soil_min_reg, soil_min_next;
    logic [savc_pkg::RAW_W-1:0] soil_max_reg, soil_max_next;
    logic [savc_pkg::RAW_W-1:0] soil_dry_reg, soil_dry_next;
    logic [savc_pkg::RAW_W-1:0] soil_wet_reg, soil_wet_next;

    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] cnt_next [3];

    logic [savc_pkg::CHAN_W-1:0] ch_reg, ch_next;
    logic [savc_pkg::RAW_W-1:0]  avg_reg, avg_next;
    logic                        ok_reg, ok_next;
    logic [VW-1:0]               res_val_reg, res_val_next;

    logic [savc_pkg::DIV_W-1:0]  dvd_reg, dvd_next;
    logic [savc_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [savc_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [savc_pkg::DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic                        neg_reg, neg_next;

    logic [savc_pkg::BIG_W-1:0]    big_reg, big_next;
    logic [savc_pkg::BIG_W-1:0]    rhs_reg, rhs_next;
    logic [savc_pkg::MUL_W-1:0]    carry_reg, carry_next;
    logic [savc_pkg::DIGC_W-1:0]   dig_reg, dig_next;
    logic [savc_pkg::PASS_W-1:0]   pass_reg, pass_next;
    logic [savc_pkg::BIT_W-1:0]    bit_reg, bit_next;
    logic [savc_pkg::SEARCH_W-1:0] gx_reg, gx_next;
    logic                          le_reg, le_next;
    logic [savc_pkg::MUL_W-1:0]    t_reg, t_next;
    logic [savc_pkg::MUL_W-1:0]    ga_reg, ga_next;
    logic [savc_pkg::MUL_W-1:0]    gb_reg, gb_next;

    logic                        m_valid_reg, m_valid_next;
    logic [savc_pkg::CHAN_W-1:0] och_reg, och_next;
    logic                        conn_reg, conn_next;
    logic [savc_pkg::RAW_W-1:0]  oavg_reg, oavg_next;
    logic [VW-1:0]               oval_reg, oval_next;

    // Accumulator read
    logic [SUM_W-1:0] sum_sel, sum_inc;
    logic [CNT_W-1:0] cnt_sel, cnt_inc;

    // Divider step
    logic [savc_pkg::DEN_W:0]   r_shift, r_sub;
    logic                       div_ge;
    logic [savc_pkg::DEN_W-1:0] rem_step;
    logic [savc_pkg::DIV_W-1:0] dvd_step;

    // Window check and conversions
    logic [savc_pkg::RAW_W-1:0]   win_lo, win_hi;
    logic                         win_ok;
    logic [savc_pkg::RAW_W:0]     ad, wd, ad_neg, wd_neg;
    logic [savc_pkg::RAW_W-1:0]   ad_mag, wd_mag;
    logic [savc_pkg::DIV_W-1:0]   soil_num;
    logic [savc_pkg::PCT_W-1:0]   pct;
    logic [31:0]                  soil_full;
    logic [savc_pkg::TEMP_W-1:0]  temp_full;

    // Gas multiplier step
    logic [savc_pkg::MUL_W-1:0]    pow_op, cube_op, mul_op;
    logic [savc_pkg::PROD_W-1:0]   prod;
    logic [savc_pkg::BIG_W-1:0]    big_step, rhs_rot;
    logic [savc_pkg::DIG_W-1:0]    prod_dig, rhs_dig;
    logic                          le_base, le_step;
    logic [savc_pkg::SEARCH_W-1:0] trial, gx_keep, trial_nx;
    logic [savc_pkg::BIT_W-1:0]    bit_dn;
    logic [savc_pkg::MUL_W-1:0]    t_nx;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_channel = och_reg;
    assign m_connected   = conn_reg;
    assign m_average_raw = oavg_reg;
    assign m_value_q8    = $signed(oval_reg);

    always_comb begin
        case (s_channel)
            savc_pkg::CH_GAS: begin
                sum_sel = sum_reg[0];
                cnt_sel = cnt_reg[0];
            end
            savc_pkg::CH_TEMP: begin
                sum_sel = sum_reg[1];
                cnt_sel = cnt_reg[1];
            end
            savc_pkg::CH_SOIL: begin
                sum_sel = sum_reg[2];
                cnt_sel = cnt_reg[2];
            end
            default: begin
                sum_sel = '0;
                cnt_sel = '0;
            end
        endcase
        sum_inc = sum_sel + SUM_W'(s_sample);
        cnt_inc = cnt_sel + CNT_W'(1);
    end

    always_comb begin
        r_shift  = {rem_reg, dvd_reg[savc_pkg::DIV_W-1]};
        r_sub    = r_shift - {1'b0, den_reg};
        div_ge   = (r_shift >= {1'b0, den_reg});
        rem_step = div_ge ? r_sub[savc_pkg::DEN_W-1:0] : r_shift[savc_pkg::DEN_W-1:0];
        dvd_step = {dvd_reg[savc_pkg::DIV_W-2:0], div_ge};
    end

    always_comb begin
        case (ch_reg)
            savc_pkg::CH_GAS: begin
                win_lo = gas_min_reg;
                win_hi = gas_max_reg;
            end
            savc_pkg::CH_TEMP: begin
                win_lo = temp_min_reg;
                win_hi = temp_max_reg;
            end
            default: begin
                win_lo = soil_min_reg;
                win_hi = soil_max_reg;
            end
        endcase
        win_ok = (avg_reg >= win_lo) && (avg_reg <= win_hi);

        // Sign-magnitude form of (a - dry) / (wet - dry)
        ad       = {1'b0, avg_reg} - {1'b0, soil_dry_reg};
        wd       = {1'b0, soil_wet_reg} - {1'b0, soil_dry_reg};
        ad_neg   = '0 - ad;
        wd_neg   = '0 - wd;
        ad_mag   = ad[savc_pkg::RAW_W] ? ad_neg[savc_pkg::RAW_W-1:0] : ad[savc_pkg::RAW_W-1:0];
        wd_mag   = wd[savc_pkg::RAW_W] ? wd_neg[savc_pkg::RAW_W-1:0] : wd[savc_pkg::RAW_W-1:0];
        soil_num = savc_pkg::DIV_W'(ad_mag) * savc_pkg::DIV_W'(savc_pkg::PCT_FULL);

        // A negative quotient clamps to zero
        if (neg_reg) begin
            pct = '0;
        end else if (dvd_step > savc_pkg::DIV_W'(savc_pkg::PCT_FULL)) begin
            pct = savc_pkg::PCT_W'(savc_pkg::PCT_FULL);
        end else begin
            pct = dvd_step[savc_pkg::PCT_W-1:0];
        end
        soil_full = 32'(pct) << FRACTION_BITS;

        temp_full = ((savc_pkg::TEMP_W'(avg_reg) * savc_pkg::TEMP_W'(savc_pkg::TEMP_SCALE))
                     << FRACTION_BITS) + savc_pkg::TEMP_W'(savc_pkg::TEMP_HALF);
    end

    always_comb begin
        pow_op   = (state_reg == ST_GAS_RHS) ? GAS_K2Q : t_reg;
        cube_op  = (state_reg == ST_GAS_RHS) ? gb_reg : ga_reg;
        mul_op   = (pass_reg < savc_pkg::PASS_POW) ? pow_op : cube_op;
        prod     = savc_pkg::PROD_W'(big_reg[savc_pkg::DIG_W-1:0]) * savc_pkg::PROD_W'(mul_op)
                   + savc_pkg::PROD_W'(carry_reg);
        prod_dig = prod[savc_pkg::DIG_W-1:0];
        big_step = {prod_dig, big_reg[savc_pkg::BIG_W-1:savc_pkg::DIG_W]};
        rhs_dig  = rhs_reg[savc_pkg::DIG_W-1:0];
        rhs_rot  = {rhs_dig, rhs_reg[savc_pkg::BIG_W-1:savc_pkg::DIG_W]};

        // LSB-first compare: a higher digit overrides the verdict so far
        le_base = (dig_reg == '0) ? 1'b1 : le_reg;
        if (prod_dig < rhs_dig) begin
            le_step = 1'b1;
        end else if (prod_dig > rhs_dig) begin
            le_step = 1'b0;
        end else begin
            le_step = le_base;
        end

        trial    = gx_reg | (savc_pkg::SEARCH_W'(1) << bit_reg);
        gx_keep  = le_step ? trial : gx_reg;
        bit_dn   = bit_reg - savc_pkg::BIT_W'(1);
        trial_nx = gx_keep | (savc_pkg::SEARCH_W'(1) << bit_dn);
        t_nx     = {trial_nx, 1'b0} - savc_pkg::MUL_W'(1);
    end

    always_comb begin
        state_next    = state_reg;
        gas_min_next  = gas_min_reg;
        gas_max_next  = gas_max_reg;
        temp_min_next = temp_min_reg;
        temp_max_next = temp_max_reg;
        soil_min_next = soil_min_reg;
        soil_max_next = soil_max_reg;
        soil_dry_next = soil_dry_reg;
        soil_wet_next = soil_wet_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        avg_next      = avg_reg;
        ok_next       = ok_reg;
        res_val_next  = res_val_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        div_cnt_next  = div_cnt_reg;
        neg_next      = neg_reg;
        big_next      = big_reg;
        rhs_next      = rhs_reg;
        carry_next    = carry_reg;
        dig_next      = dig_reg;
        pass_next     = pass_reg;
        bit_next      = bit_reg;
        gx_next       = gx_reg;
        le_next       = le_reg;
        t_next        = t_reg;
        ga_next       = ga_reg;
        gb_next       = gb_reg;
        m_valid_next  = m_valid_reg;
        och_next      = och_reg;
        conn_next     = conn_reg;
        oavg_next     = oavg_reg;
        oval_next     = oval_reg;

        if (cfg_wr_en) begin
            unique case (savc_pkg::cfg_idx_t'(cfg_addr))
                savc_pkg::REG_GAS_MIN:  gas_min_next  = cfg_wdata;
                savc_pkg::REG_GAS_MAX:  gas_max_next  = cfg_wdata;
                savc_pkg::REG_TEMP_MIN: temp_min_next = cfg_wdata;
                savc_pkg::REG_TEMP_MAX: temp_max_next = cfg_wdata;
                savc_pkg::REG_SOIL_MIN: soil_min_next = cfg_wdata;
                savc_pkg::REG_SOIL_MAX: soil_max_next = cfg_wdata;
                savc_pkg::REG_SOIL_DRY: soil_dry_next = cfg_wdata;
                savc_pkg::REG_SOIL_WET: soil_wet_next = cfg_wdata;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_valid && (s_channel != savc_pkg::CH_NONE)) begin
                    if (cnt_inc == CNT_FULL) begin
                        sum_next[s_channel] = '0;
                        cnt_next[s_channel] = '0;
                        ch_next      = s_channel;
                        dvd_next     = savc_pkg::DIV_W'(sum_inc);
                        den_next     = AVG_DEN;
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV_AVG;
                    end else begin
                        sum_next[s_channel] = sum_inc;
                        cnt_next[s_channel] = cnt_inc;
                    end
                end
            end

            ST_DIV_AVG, ST_DIV_SOIL: begin
                dvd_next     = dvd_step;
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + savc_pkg::DIVC_W'(1);
                if (div_cnt_reg == savc_pkg::DIV_LAST) begin
                    if (state_reg == ST_DIV_AVG) begin
                        avg_next   = dvd_step[savc_pkg::RAW_W-1:0];
                        state_next = ST_CHECK;
                    end else begin
                        res_val_next = soil_full[VW-1:0];
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_CHECK: begin
                ok_next    = win_ok;
                state_next = ST_DONE;
                case (ch_reg)
                    savc_pkg::CH_GAS: begin
                        if (!win_ok) begin
                            res_val_next = GAS_SENT;
                        end else if (avg_reg == savc_pkg::RAW_FULL) begin
                            res_val_next = '0;
                        end else begin
                            // Average zero stands for a very high sensor resistance
                            if (avg_reg == '0) begin
                                ga_next = savc_pkg::MUL_W'(savc_pkg::GAS_ZERO_A);
                                gb_next = savc_pkg::MUL_W'(1);
                            end else begin
                                ga_next = savc_pkg::MUL_W'(savc_pkg::RAW_FULL - avg_reg);
                                gb_next = savc_pkg::MUL_W'(avg_reg);
                            end
                            big_next   = savc_pkg::BIG_W'(1);
                            carry_next = '0;
                            dig_next   = '0;
                            pass_next  = '0;
                            state_next = ST_GAS_RHS;
                        end
                    end
                    savc_pkg::CH_TEMP: begin
                        res_val_next = win_ok
                            ? temp_full[VW+savc_pkg::TEMP_SHIFT-1:savc_pkg::TEMP_SHIFT]
                            : TEMP_SENT;
                    end
                    default: begin
                        if (!win_ok) begin
                            res_val_next = GAS_SENT;
                        end else if (wd == '0) begin
                            res_val_next = '0;
                        end else begin
                            dvd_next     = soil_num;
                            den_next     = wd_mag;
                            rem_next     = '0;
                            div_cnt_next = '0;
                            neg_next     = ad[savc_pkg::RAW_W] ^ wd[savc_pkg::RAW_W];
                            state_next   = ST_DIV_SOIL;
                        end
                    end
                endcase
            end

            ST_GAS_RHS, ST_GAS_TRY: begin
                big_next   = big_step;
                carry_next = prod[savc_pkg::PROD_W-1:savc_pkg::DIG_W];
                dig_next   = dig_reg + savc_pkg::DIGC_W'(1);
                // Compare against the right-hand side during the last pass of a trial
                if ((state_reg == ST_GAS_TRY) && (pass_reg == savc_pkg::PASS_LAST)) begin
                    rhs_next = rhs_rot;
                    le_next  = le_step;
                end
                if (dig_reg == savc_pkg::DIG_LAST) begin
                    dig_next   = '0;
                    carry_next = '0;
                    pass_next  = pass_reg + savc_pkg::PASS_W'(1);
                    if (pass_reg == savc_pkg::PASS_LAST) begin
                        pass_next = '0;
                        big_next  = savc_pkg::BIG_W'(1);
                        if (state_reg == ST_GAS_RHS) begin
                            rhs_next   = big_step;
                            gx_next    = '0;
                            bit_next   = savc_pkg::BIT_TOP;
                            t_next     = '1;
                            state_next = ST_GAS_TRY;
                        end else begin
                            gx_next = gx_keep;
                            if (bit_reg == '0) begin
                                res_val_next = gx_keep[VW-1:0];
                                state_next   = ST_DONE;
                            end else begin
                                bit_next = bit_dn;
                                t_next   = t_nx;
                            end
                        end
                    end
                end
            end

            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    och_next     = ch_reg;
                    conn_next    = ok_reg;
                    oavg_next    = avg_reg;
                    oval_next    = res_val_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gas_min_reg  <= savc_pkg::GAS_MIN_RST;
            gas_max_reg  <= savc_pkg::GAS_MAX_RST;
            temp_min_reg <= savc_pkg::TEMP_MIN_RST;
            temp_max_reg <= savc_pkg::TEMP_MAX_RST;
            soil_min_reg <= savc_pkg::SOIL_MIN_RST;
            soil_max_reg <= savc_pkg::SOIL_MAX_RST;
            soil_dry_reg <= savc_pkg::SOIL_DRY_RST;
            soil_wet_reg <= savc_pkg::SOIL_WET_RST;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gas_min_reg  <= gas_min_next;
            gas_max_reg  <= gas_max_next;
            temp_min_reg <= temp_min_next;
            temp_max_reg <= temp_max_next;
            soil_min_reg <= soil_min_next;
            soil_max_reg <= soil_max_next;
            soil_dry_reg <= soil_dry_next;
            soil_wet_reg <= soil_wet_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        ch_reg      <= ch_next;
        avg_reg     <= avg_next;
        ok_reg      <= ok_next;
        res_val_reg <= res_val_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        big_reg     <= big_next;
        rhs_reg     <= rhs_next;
        carry_reg   <= carry_next;
        dig_reg     <= dig_next;
        pass_reg    <= pass_next;
        bit_reg     <= bit_next;
        gx_reg      <= gx_next;
        le_reg      <= le_next;
        t_reg       <= t_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        och_reg     <= och_next;
        conn_reg    <= conn_next;
        oavg_reg    <= oavg_next;
        oval_reg    <= oval_next;
    end

    `SAVC_ASSERT_IMPLY(a_out_channel_real, aclk, aresetn, m_valid_reg, och_reg != savc_pkg::CH_NONE, "result reports the unused channel code")

    `SAVC_ASSERT_IMPLY(a_fail_sentinel, aclk, aresetn, m_valid_reg && !conn_reg, ((och_reg == savc_pkg::CH_TEMP) && (oval_reg == TEMP_SENT)) || ((och_reg != savc_pkg::CH_TEMP) && (oval_reg == GAS_SENT)), "failed window check without its sentinel value")

    `SAVC_ASSERT_IMPLY(a_count_below_full, aclk, aresetn, 1'b1, (cnt_reg[0] < CNT_FULL) && (cnt_reg[1] < CNT_FULL) && (cnt_reg[2] < CNT_FULL), "sample count left at or above a full average")

    `SAVC_ASSERT_NEXT(a_done_delivers, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == ST_IDLE), "finished result not moved to the output register")

endmodule

// ===== dv/tb_sensor_average_validate_convert_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_average_validate_convert_top
// Drives tagged ADC samples into the averaging block and checks every reading
// against a typed table entry or an in-bench predictor of the average, window
// check and conversion. The directed table of full averages comes first, then
// random phases, each under its own register setting, with random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_sensor_average_validate_convert_top;
    import savc_pkg::*;

    localparam int SAMPLES_PER_AVG = 20;
    localparam int FRAC_BITS       = 8;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 1500;
    localparam int NUM_PHASES      = 6;
    localparam int PHASE_SAMPLES   = 240;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int MAX_REPORTS     = 10;

    localparam int unsigned GAS_SCALE2   = 40 << FRAC_BITS;
    localparam longint      GAS_OPEN_RES = 1000000;
    localparam int          TEMP_MULT    = 500;
    localparam int          TEMP_ROUND   = 512;
    localparam int          TEMP_DIV_SH  = 10;
    localparam int          PCT_MAX      = 100;

    localparam logic [VALUE_W-1:0] GAS_FAIL_Q8  = VALUE_W'(-(1 << FRAC_BITS));
    localparam logic [VALUE_W-1:0] SOIL_FAIL_Q8 = VALUE_W'(-(1 << FRAC_BITS));
    localparam logic [VALUE_W-1:0] TEMP_FAIL_Q8 = VALUE_W'(-(1000 << FRAC_BITS));
    localparam logic [VALUE_W-1:0] SOIL_FULL_Q8 = VALUE_W'(PCT_MAX << FRAC_BITS);
    localparam logic [VALUE_W-1:0] ZERO_Q8      = '0;

    typedef logic [7:0][RAW_W-1:0] reg_set_t;

    localparam reg_set_t RESET_REGS = {SOIL_WET_RST, SOIL_DRY_RST, SOIL_MAX_RST,
                                       SOIL_MIN_RST, TEMP_MAX_RST, TEMP_MIN_RST,
                                       GAS_MAX_RST, GAS_MIN_RST};

    typedef struct packed {
        chan_t              chan;
        logic               conn;
        logic [RAW_W-1:0]   avg;
        logic [VALUE_W-1:0] value;
    } reading_t;

    // One row is a full average: an optional register change, then a burst of equal samples.
    typedef struct packed {
        logic               cfg_change;
        cfg_idx_t           reg_idx;
        logic [RAW_W-1:0]   reg_val;
        chan_t              chan;
        logic [RAW_W-1:0]   level;
        logic               has_typed;
        logic               want_conn;
        logic [VALUE_W-1:0] want_value;
    } burst_t;

    localparam int NUM_BURSTS = 23;

    burst_t burst_table [NUM_BURSTS] = '{
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_GAS,  10'd0,    1'b1, 1'b0, GAS_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_GAS,  10'd1023, 1'b1, 1'b0, GAS_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_GAS,  10'd50,   1'b0, 1'b0, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_GAS,  10'd950,  1'b0, 1'b0, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd0,    1'b1, 1'b0, TEMP_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd1023, 1'b1, 1'b0, TEMP_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd99,   1'b1, 1'b0, TEMP_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd100,  1'b0, 1'b0, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd600,  1'b0, 1'b0, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_TEMP, 10'd601,  1'b1, 1'b0, TEMP_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd0,    1'b1, 1'b0, SOIL_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd1023, 1'b1, 1'b0, SOIL_FAIL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd800,  1'b1, 1'b1, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd300,  1'b1, 1'b1, SOIL_FULL_Q8},
        // above the dry point of an inverted map: clamp to zero percent
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd990,  1'b1, 1'b1, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd10,   1'b1, 1'b1, SOIL_FULL_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_SOIL, 10'd550,  1'b0, 1'b0, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_NONE, 10'd1023, 1'b0, 1'b0, ZERO_Q8},
        // gas ratio of zero
        '{1'b1, REG_GAS_MAX,  10'd1023, CH_GAS, 10'd1023, 1'b1, 1'b1, ZERO_Q8},
        // gas average of zero: open-circuit resistance
        '{1'b1, REG_GAS_MIN,  10'd0,   CH_GAS,  10'd0,    1'b0, 1'b0, ZERO_Q8},
        // inverted temperature window
        '{1'b1, REG_TEMP_MIN, 10'd700, CH_TEMP, 10'd650,  1'b1, 1'b0, TEMP_FAIL_Q8},
        // dry and wet points equal
        '{1'b1, REG_SOIL_WET, 10'd800, CH_SOIL, 10'd700,  1'b1, 1'b1, ZERO_Q8},
        '{1'b0, REG_GAS_MIN,  10'd0,   CH_NONE, 10'd0,    1'b0, 1'b0, ZERO_Q8}
    };

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CHAN_W-1:0]   s_channel     = '0;
    logic [RAW_W-1:0]    s_sample      = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [CHAN_W-1:0]   m_out_channel;
    logic                m_connected;
    logic [RAW_W-1:0]    m_average_raw;
    logic [VALUE_W-1:0]  m_value_q8;
    logic                cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr     = '0;
    logic [RAW_W-1:0]    cfg_wdata     = '0;

    reg_set_t         reg_now;
    int unsigned      acc_sum [3];
    int unsigned      acc_cnt [3];
    logic [RAW_W-1:0] level_now [3];
    reading_t         reading_q [$];

    bit   src_gaps   = 1'b0;
    bit   sink_gaps  = 1'b0;
    logic hold_go    = 1'b0;
    int   errors     = 0;
    int   samples_sent  = 0;
    int   reg_loads     = 0;
    int   in_window_cnt = 0;
    int   chan_readings [3] = '{0, 0, 0};
    int   cycles        = 0;

    always #HALF_PERIOD aclk = ~aclk;

    sensor_average_validate_convert_top #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVG),
        .FRACTION_BITS       (FRAC_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_connected   (m_connected),
        .m_average_raw (m_average_raw),
        .m_value_q8    (m_value_q8),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Largest x with x - 1/2 <= 20 * 2^F * (b/a)^0.3, found by exact bisection
    // on (2x - 1)^10 * a^3 <= (40 * 2^F)^10 * b^3.
    function automatic logic [VALUE_W-1:0] gas_ppm_q8(input int unsigned avg);
        logic [383:0] lhs;
        logic [383:0] rhs;
        longint unsigned res_a;
        longint unsigned res_b;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (avg >= RAW_MAX) return '0;
        if (avg == 0) begin
            res_a = GAS_OPEN_RES;
            res_b = 1;
        end else begin
            res_a = RAW_MAX - avg;
            res_b = avg;
        end
        lo = 0;
        hi = 1 << 25;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            lhs = 384'd1;
            rhs = 384'd1;
            repeat (10) begin
                lhs = lhs * 384'(2 * mid - 1);
                rhs = rhs * 384'(GAS_SCALE2);
            end
            repeat (3) begin
                lhs = lhs * 384'(res_a);
                rhs = rhs * 384'(res_b);
            end
            if (lhs <= rhs) lo = mid;
            else hi = mid;
        end
        return VALUE_W'(lo);
    endfunction

    // Accumulate one sample; returns 1 with the reading when the average completes.
    function automatic bit predict_reading(input chan_t ch, input logic [RAW_W-1:0] smp,
                                           output reading_t r);
        int unsigned avg;
        int          ci;
        int          lo;
        int          hi;
        int          dry;
        int          wet;
        int          pct;
        longint      t;
        r = '0;
        if (ch == CH_NONE) return 1'b0;
        ci = int'(ch);
        acc_sum[ci] += smp;
        acc_cnt[ci] += 1;
        if (acc_cnt[ci] < SAMPLES_PER_AVG) return 1'b0;
        avg = acc_sum[ci] / SAMPLES_PER_AVG;
        acc_sum[ci] = 0;
        acc_cnt[ci] = 0;
        r.chan = ch;
        r.avg  = avg[RAW_W-1:0];
        case (ch)
            CH_GAS: begin
                lo = reg_now[REG_GAS_MIN];
                hi = reg_now[REG_GAS_MAX];
                r.conn  = (avg >= lo) && (avg <= hi);
                r.value = r.conn ? gas_ppm_q8(avg) : GAS_FAIL_Q8;
            end
            CH_TEMP: begin
                lo = reg_now[REG_TEMP_MIN];
                hi = reg_now[REG_TEMP_MAX];
                r.conn = (avg >= lo) && (avg <= hi);
                t = ((longint'(avg) * TEMP_MULT) << FRAC_BITS) + TEMP_ROUND;
                r.value = r.conn ? VALUE_W'(t >> TEMP_DIV_SH) : TEMP_FAIL_Q8;
            end
            default: begin
                lo  = reg_now[REG_SOIL_MIN];
                hi  = reg_now[REG_SOIL_MAX];
                dry = reg_now[REG_SOIL_DRY];
                wet = reg_now[REG_SOIL_WET];
                r.conn = (avg >= lo) && (avg <= hi);
                pct = 0;
                if (wet != dry) pct = (int'(avg) - dry) * PCT_MAX / (wet - dry);
                if (pct < 0) pct = 0;
                if (pct > PCT_MAX) pct = PCT_MAX;
                r.value = r.conn ? VALUE_W'(pct << FRAC_BITS) : SOIL_FAIL_Q8;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [RAW_W-1:0] clamp_raw(input int v);
        if (v < 0) return '0;
        if (v > RAW_MAX) return RAW_FULL;
        return RAW_W'(v);
    endfunction

    // Aim averages at the window edges, the map points and the extremes.
    function automatic logic [RAW_W-1:0] pick_level(input chan_t ch);
        int lo;
        int hi;
        int v;
        case (ch)
            CH_GAS: begin
                lo = reg_now[REG_GAS_MIN];
                hi = reg_now[REG_GAS_MAX];
            end
            CH_TEMP: begin
                lo = reg_now[REG_TEMP_MIN];
                hi = reg_now[REG_TEMP_MAX];
            end
            default: begin
                lo = reg_now[REG_SOIL_MIN];
                hi = reg_now[REG_SOIL_MAX];
            end
        endcase
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = RAW_MAX;
            2, 3:    v = lo + int'($urandom_range(4)) - 2;
            4, 5:    v = hi + int'($urandom_range(4)) - 2;
            6:       v = int'(reg_now[REG_SOIL_DRY]) + int'($urandom_range(6)) - 3;
            7:       v = int'(reg_now[REG_SOIL_WET]) + int'($urandom_range(6)) - 3;
            default: v = $urandom_range(RAW_MAX);
        endcase
        return clamp_raw(v);
    endfunction

    function automatic reg_set_t phase_regs(input int phase);
        reg_set_t regs;
        int i;
        regs = RESET_REGS;
        case (phase)
            1: begin
                regs[REG_GAS_MIN]  = '0;
                regs[REG_GAS_MAX]  = RAW_FULL;
                regs[REG_TEMP_MIN] = '0;
                regs[REG_TEMP_MAX] = RAW_FULL;
                regs[REG_SOIL_MIN] = '0;
                regs[REG_SOIL_MAX] = RAW_FULL;
                regs[REG_SOIL_DRY] = RAW_FULL;
                regs[REG_SOIL_WET] = '0;
            end
            2: begin
                regs[REG_GAS_MIN]  = 10'd400;
                regs[REG_GAS_MAX]  = 10'd440;
                regs[REG_TEMP_MIN] = 10'd200;
                regs[REG_TEMP_MAX] = 10'd230;
                regs[REG_SOIL_MIN] = 10'd480;
                regs[REG_SOIL_MAX] = 10'd540;
                regs[REG_SOIL_DRY] = '0;
                regs[REG_SOIL_WET] = RAW_FULL;
            end
            3: regs = '0;
            4: regs = '1;
            5: for (i = 0; i < 8; i++) regs[i] = RAW_W'($urandom_range(RAW_MAX));
            default: regs = RESET_REGS;
        endcase
        return regs;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Write all eight registers back to back; the block must be idle.
    task automatic load_regs(input reg_set_t vals);
        int i;
        for (i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        reg_now = vals;
        reg_loads++;
    endtask

    // Stop sending, drain every pending reading, then let the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (reading_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_sample(input chan_t ch, input logic [RAW_W-1:0] smp,
                               input bit use_typed, input reading_t typed_reading);
        reading_t got;
        if (src_gaps) begin
            while ($urandom_range(99) < 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        if (predict_reading(ch, smp, got)) reading_q.push_back(use_typed ? typed_reading : got);
    endtask

    // Output-side pacing, including the long hold-off when requested.
    initial begin : sink_pacing
        int held;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go <= 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end
            m_ready <= !(sink_gaps && ($urandom_range(99) < 10));
        end
    end

    always @(posedge aclk) begin : reading_check
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reading_q.size() == 0) begin
                note_error($sformatf("unexpected reading: chan %0d conn %0d avg %0d value %0d",
                                     m_out_channel, m_connected, m_average_raw,
                                     $signed(m_value_q8)));
            end else begin
                want = reading_q.pop_front();
                if (m_out_channel !== want.chan)
                    note_error($sformatf("out_channel: expected %0d, got %0d",
                                         want.chan, m_out_channel));
                if (m_connected !== want.conn)
                    note_error($sformatf("connected (chan %0d avg %0d): expected %0d, got %0d",
                                         want.chan, want.avg, want.conn, m_connected));
                if (m_average_raw !== want.avg)
                    note_error($sformatf("average_raw (chan %0d): expected %0d, got %0d",
                                         want.chan, want.avg, m_average_raw));
                if (m_value_q8 !== want.value)
                    note_error($sformatf("value_q8 (chan %0d avg %0d): expected %0d, got %0d",
                                         want.chan, want.avg, $signed(want.value),
                                         $signed(m_value_q8)));
            end
            if (m_out_channel <= CH_SOIL) chan_readings[m_out_channel]++;
            if (m_connected === 1'b1) in_window_cnt++;
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d readings pending", cycles, reading_q.size());
        $display("tb_sensor_average_validate_convert_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        reading_t         typed_reading;
        reg_set_t         regs;
        chan_t            ch;
        int               counted;
        int unsigned      roll;
        logic [RAW_W-1:0] smp;
        int               phase;
        int               i;

        reg_now = RESET_REGS;
        for (i = 0; i < 3; i++) begin
            acc_sum[i]   = 0;
            acc_cnt[i]   = 0;
            level_now[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        for (i = 0; i < NUM_BURSTS; i++) begin
            if (burst_table[i].cfg_change) begin
                wait_idle();
                regs = reg_now;
                regs[burst_table[i].reg_idx] = burst_table[i].reg_val;
                load_regs(regs);
            end
            typed_reading = '{burst_table[i].chan, burst_table[i].want_conn,
                              burst_table[i].level, burst_table[i].want_value};
            repeat (SAMPLES_PER_AVG)
                send_sample(burst_table[i].chan, burst_table[i].level,
                            burst_table[i].has_typed, typed_reading);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            load_regs(phase_regs(phase));
            src_gaps  = (phase != 1) && (phase != 2);
            sink_gaps = (phase != 2);
            // stall the output while samples keep coming, so the input backs up
            if (phase == 1) hold_go <= 1'b1;
            counted = 0;
            while (counted < PHASE_SAMPLES) begin
                roll = $urandom_range(99);
                ch = (roll < 25) ? CH_GAS : (roll < 55) ? CH_TEMP :
                     (roll < 92) ? CH_SOIL : CH_NONE;
                if (ch == CH_NONE) begin
                    smp = RAW_W'($urandom_range(RAW_MAX));
                end else begin
                    counted++;
                    if (acc_cnt[ch] == 0) level_now[ch] = pick_level(ch);
                    if ($urandom_range(99) < 80)
                        smp = clamp_raw(int'(level_now[ch]) + int'($urandom_range(4)) - 2);
                    else
                        smp = RAW_W'($urandom_range(RAW_MAX));
                end
                send_sample(ch, smp, 1'b0, typed_reading);
            end
        end

        wait_idle();
        $display("covered %0d samples over %0d register settings, %0d cycles",
                 samples_sent, reg_loads, cycles);
        $display("checked readings: gas %0d, temperature %0d, soil %0d (%0d in window)",
                 chan_readings[0], chan_readings[1], chan_readings[2], in_window_cnt);
        if (errors == 0 && reading_q.size() == 0) begin
            $display("tb_sensor_average_validate_convert_top OK");
        end else begin
            $display("%0d mismatches, %0d readings never arrived", errors, reading_q.size());
            $display("tb_sensor_average_validate_convert_top NOT OK");
        end
        $finish;
    end

endmodule
